@@ design/aisbm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aisbm_pkg
// Shared types, constants and helper functions of the AIS binary message
// sentence encoder.
// ----------------------------------------------------------------------------
package aisbm_pkg;

  localparam int unsigned MAX_PAYLOAD_BITS = 952;
  localparam int unsigned MAX_SENTENCES    = 9;

  localparam int unsigned FIRST_LIMIT_ABM = 288;
  localparam int unsigned FIRST_LIMIT_BBM = 348;
  localparam int unsigned NEXT_LIMIT_STEP = 360;
  localparam int unsigned BIT_LIMIT_MAX   = 1023;

  // One decimal digit weight of the nine-digit identity, top position.
  localparam int unsigned DEC_TOP  = 100000000;
  localparam int unsigned DEC_WRAP = 1000000000;

  localparam int unsigned CFG_IDX_W = 1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_TALKER_FIRST  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_TALKER_SECOND = 1'b1;

  localparam logic [7:0] TALKER_FIRST_RST  = 8'd69;
  localparam logic [7:0] TALKER_SECOND_RST = 8'd73;

  // Error codes.
  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_TOO_LONG = 2'd1;
  localparam logic [1:0] ERR_CHANNEL  = 2'd2;
  localparam logic [1:0] ERR_MSG_ID   = 2'd3;

  // Message ids.
  localparam logic [5:0] ID_ADDR_A  = 6'd6;
  localparam logic [5:0] ID_BCAST_A = 6'd8;
  localparam logic [5:0] ID_ADDR_B  = 6'd12;
  localparam logic [5:0] ID_BCAST_B = 6'd14;

  // Characters.
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_B     = 8'h42;
  localparam logic [7:0] CH_M     = 8'h4D;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ERR,
    S_OPEN,
    S_MMSI,
    S_HDR,
    S_GAP,
    S_CHECK,
    S_PAD,
    S_CLOSE,
    S_BIT,
    S_FLUSH
  } state_e;

  // Queue entry: one input item with its header already classified.
  typedef struct packed {
    logic        first;
    logic [7:0]  data;
    logic [29:0] mmsi;
    logic [5:0]  id;
    logic [1:0]  chan;
    logic [9:0]  bits;
    logic [1:0]  err;
    logic        addr;
    logic [3:0]  total;
    logic [9:0]  limit;
    logic [2:0]  fill;
  } item_t;

  // One result character with its flags.
  typedef struct packed {
    logic [7:0] ch;
    logic       sent_end;
    logic       msg_end;
    logic [1:0] err;
  } res_t;

  function automatic logic [7:0] armor(input logic [5:0] v);
    logic [7:0] w;
    w = {2'b00, v};
    return (v < 6'd40) ? w + 8'd48 : w + 8'd56;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    logic [7:0] w;
    w = {4'h0, v};
    return (v < 4'd10) ? w + CH_ZERO : w + 8'd55;
  endfunction

endpackage
`default_nettype wire

@@ design/ais_binary_message_sentence_encoder.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ais_binary_message_sentence_encoder
// Turns AIS binary message payload bytes into NMEA ABM/BBM sentence text.
// ----------------------------------------------------------------------------
// Feed one payload byte per item, the first one flagged with first_of_message
// and carrying the header (destination MMSI, message id, channel, bit count).
// The block streams ASCII characters of the ABM (ids 6, 12) or BBM (ids 8, 14)
// sentences, one per output item, with sentence_end on each closing LF,
// message_end on the last character of the message and run_last on the last
// character caused by each input item. A bad header gives a single item with
// out_char 0 and an error code. Timing: the sequencer handles one payload bit
// per cycle and one header or trailer character per cycle. A payload byte is
// taken from the queue, its bits are walked one by one and its held last
// character is released, plus a check step where a sentence boundary or the
// end of the message falls. Each sentence header, with the destination MMSI
// in the first one of an addressed message, ends in a check step. At the end
// of the message a pad step for the padded last symbol comes before the
// trailer. Output stalls hold the sequencer once a character is waiting in
// the hold stage. A two-entry input queue in front of the sequencer and an
// output register behind it let either side stall alone. The user must write
// the talker characters through the configuration port only while the block
// is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module ais_binary_message_sentence_encoder (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [aisbm_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [7:0]                      cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            first_of_message_i,
  input  logic [7:0]                      payload_byte_i,
  input  logic [29:0]                     dest_mmsi_i,
  input  logic [5:0]                      message_id_i,
  input  logic [2:0]                      radio_channel_i,
  input  logic [9:0]                      bit_count_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [7:0]                      out_char_o,
  output logic                            sentence_end_o,
  output logic                            message_end_o,
  output logic                            run_last_o,
  output logic [1:0]                      error_code_o
);
  import aisbm_pkg::*;

  logic [7:0] talker_first_q, talker_second_q;
  item_t      item;
  logic       item_valid, item_pop;

  // Configuration writes are always taken.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      talker_first_q  <= TALKER_FIRST_RST;
      talker_second_q <= TALKER_SECOND_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_TALKER_FIRST:  talker_first_q  <= cfg_data_i;
        REG_TALKER_SECOND: talker_second_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Front: accept, classify the header, queue.
  aisbm_front u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .first_of_message_i (first_of_message_i),
    .payload_byte_i     (payload_byte_i),
    .dest_mmsi_i        (dest_mmsi_i),
    .message_id_i       (message_id_i),
    .radio_channel_i    (radio_channel_i),
    .bit_count_i        (bit_count_i),
    .item_o             (item),
    .item_valid_o       (item_valid),
    .item_pop_i         (item_pop)
  );

  // Back: sequence the sentence characters.
  aisbm_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .item_i          (item),
    .item_valid_i    (item_valid),
    .item_pop_o      (item_pop),
    .talker_first_i  (talker_first_q),
    .talker_second_i (talker_second_q),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_char_o      (out_char_o),
    .sentence_end_o  (sentence_end_o),
    .message_end_o   (message_end_o),
    .run_last_o      (run_last_o),
    .error_code_o    (error_code_o)
  );

  // An error item stands alone: it ends the message and the input item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (error_code_o != ERR_NONE) |-> message_end_o && run_last_o)
    else $error("error item without message end or run last");

  // Every sentence closes on a line feed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && sentence_end_o |-> out_char_o == CH_LF)
    else $error("sentence end on a character other than LF");

  // A message that completes normally ends on a sentence end, and that
  // character is the last one of its input item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && message_end_o && (error_code_o == ERR_NONE)
      |-> sentence_end_o && run_last_o)
    else $error("message end outside a closing line feed");

endmodule
`default_nettype wire

@@ design/aisbm_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aisbm_front
// Input side: accept items, classify message headers and queue them for the
// sentence sequencer.
// ----------------------------------------------------------------------------
module aisbm_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               first_of_message_i,
  input  logic [7:0]         payload_byte_i,
  input  logic [29:0]        dest_mmsi_i,
  input  logic [5:0]         message_id_i,
  input  logic [2:0]         radio_channel_i,
  input  logic [9:0]         bit_count_i,
  output aisbm_pkg::item_t   item_o,
  output logic               item_valid_o,
  input  logic               item_pop_i
);
  import aisbm_pkg::*;

  item_t       cls;
  logic        addr;
  logic [10:0] lim_w;
  logic [10:0] bits_w;
  logic [3:0]  need;
  logic [21:0] prod;
  logic [7:0]  quot;
  logic [9:0]  rem_w;
  logic [2:0]  rem;

  item_t       entry_q [2];
  logic        wr_q, rd_q;
  logic [1:0]  cnt_q;
  logic        push;

  always_comb begin
    addr   = (message_id_i == ID_ADDR_A) || (message_id_i == ID_ADDR_B);
    lim_w  = addr ? 11'(FIRST_LIMIT_ABM) : 11'(FIRST_LIMIT_BBM);
    bits_w = {1'b0, bit_count_i};
    // Sentences needed: one, plus one per started step beyond the first limit.
    need   = 4'd1 + {3'b0, bits_w > lim_w}
                  + {3'b0, bits_w > lim_w + 11'(NEXT_LIMIT_STEP)}
                  + {3'b0, bits_w > lim_w + 11'(2 * NEXT_LIMIT_STEP)};
    // bit_count mod 6 by reciprocal multiply; exact for ten-bit values.
    prod   = 22'(bit_count_i) * 22'd2731;
    quot   = prod[21:14];
    rem_w  = bit_count_i - (10'({quot, 2'b00}) + 10'({quot, 1'b0}));
    rem    = rem_w[2:0];

    cls.first = first_of_message_i;
    cls.data  = payload_byte_i;
    cls.mmsi  = (dest_mmsi_i >= 30'(DEC_WRAP)) ? dest_mmsi_i - 30'(DEC_WRAP)
                                                 : dest_mmsi_i;
    cls.id    = message_id_i;
    cls.chan  = radio_channel_i[1:0];
    cls.bits  = bit_count_i;
    cls.addr  = addr;
    cls.limit = lim_w[9:0];
    cls.total = (need > 4'(MAX_SENTENCES)) ? 4'(MAX_SENTENCES) : need;
    cls.fill  = (rem == 3'd0) ? 3'd0 : 3'd6 - rem;
    if (bit_count_i > 10'(MAX_PAYLOAD_BITS)) begin
      cls.err = ERR_TOO_LONG;
    end else if (radio_channel_i >= 3'd4) begin
      cls.err = ERR_CHANNEL;
    end else if (!addr && message_id_i != ID_BCAST_A && message_id_i != ID_BCAST_B) begin
      cls.err = ERR_MSG_ID;
    end else begin
      cls.err = ERR_NONE;
    end
  end

  assign in_ready_o   = (cnt_q != 2'd2);
  assign push         = in_valid_i && in_ready_o;
  assign item_valid_o = (cnt_q != 2'd0);
  assign item_o       = entry_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) begin
        wr_q <= ~wr_q;
      end
      if (item_pop_i) begin
        rd_q <= ~rd_q;
      end
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, item_pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_q] <= cls;
    end
  end

endmodule
`default_nettype wire

@@ design/aisbm_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aisbm_back
// Sentence sequencer: walks the header, payload bits and trailer of each
// sentence and hands characters to a one-deep hold stage and output register.
// ----------------------------------------------------------------------------
module aisbm_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  aisbm_pkg::item_t  item_i,
  input  logic              item_valid_i,
  output logic              item_pop_o,
  input  logic [7:0]        talker_first_i,
  input  logic [7:0]        talker_second_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [7:0]        out_char_o,
  output logic              sentence_end_o,
  output logic              message_end_o,
  output logic              run_last_o,
  output logic [1:0]        error_code_o
);
  import aisbm_pkg::*;

  state_e      state_q, state_d;
  logic [4:0]  k_q, k_d;
  logic [3:0]  seq_q, seq_d;
  logic [9:0]  pos_q, pos_d;
  logic [5:0]  res_q, res_d;
  logic [2:0]  cnt_q, cnt_d;
  logic [3:0]  idx_q, idx_d;
  logic [3:0]  tot_q, tot_d;
  logic [9:0]  lim_q, lim_d;
  logic [7:0]  csum_q, csum_d;
  logic [29:0] mm_q, mm_d;
  logic [5:0]  id_q, id_d;
  logic [1:0]  chan_q, chan_d;
  logic [9:0]  bits_q, bits_d;
  logic [2:0]  fill_q, fill_d;
  logic [1:0]  err_q, err_d;
  logic        addr_q, addr_d;
  logic        busy_q, busy_d;
  logic [7:0]  data_q, data_d;
  logic [2:0]  bit_q, bit_d;
  logic        more_q, more_d;
  logic        final_q, final_d;

  logic        hold_v_q, out_v_q;
  res_t        hold_q, out_q;
  logic        out_rl_q;

  res_t        e_res;
  logic        emit, e_sum;
  logic        out_free, go, do_push, do_flush;

  logic        final_cond, hit_next, cur_bit;
  logic [5:0]  res_next, pad_sym;
  logic [3:0]  mm_dig;
  logic [29:0] mm_sub, mm_rem;
  logic [10:0] lim_sum;
  logic [10:0] pos_inc;

  // ---- helpers --------------------------------------------------------------
  always_comb begin
    mm_dig = 4'd0;
    mm_sub = 30'd0;
    for (int d = 1; d < 10; d++) begin
      if (mm_q >= 30'(d * DEC_TOP)) begin
        mm_dig = 4'(d);
        mm_sub = 30'(d * DEC_TOP);
      end
    end
    mm_rem     = mm_q - mm_sub;
    cur_bit    = data_q[bit_q];
    res_next   = {res_q[4:0], cur_bit};
    pad_sym    = 6'(res_q << (3'd6 - cnt_q));
    pos_inc    = {1'b0, pos_q} + 11'd1;
    lim_sum    = {1'b0, lim_q} + 11'(NEXT_LIMIT_STEP);
    final_cond = (pos_q >= bits_q)
              || ((pos_q >= lim_q) && ({1'b0, idx_q} + 5'd1 >= {1'b0, tot_q}));
    hit_next   = (pos_inc >= {1'b0, bits_q}) || (pos_inc >= {1'b0, lim_q});
  end

  // ---- character outputs per state ------------------------------------------
  always_comb begin
    emit        = 1'b0;
    e_sum       = 1'b1;
    e_res.ch    = CH_COMMA;
    e_res.sent_end = 1'b0;
    e_res.msg_end  = 1'b0;
    e_res.err   = ERR_NONE;
    unique case (state_q)
      S_ERR: begin
        emit          = 1'b1;
        e_sum         = 1'b0;
        e_res.ch      = 8'd0;
        e_res.msg_end = 1'b1;
        e_res.err     = err_q;
      end
      S_OPEN: begin
        emit  = 1'b1;
        e_sum = (k_q != 5'd0);
        case (k_q)
          5'd0:    e_res.ch = CH_BANG;
          5'd1:    e_res.ch = talker_first_i;
          5'd2:    e_res.ch = talker_second_i;
          5'd3:    e_res.ch = addr_q ? CH_A : CH_B;
          5'd4:    e_res.ch = CH_B;
          5'd5:    e_res.ch = CH_M;
          5'd7:    e_res.ch = CH_ZERO + {4'h0, tot_q};
          5'd9:    e_res.ch = CH_ZERO + {4'h0, idx_q} + 8'd1;
          5'd11:   e_res.ch = CH_ZERO + {4'h0, seq_q};
          default: e_res.ch = CH_COMMA;
        endcase
      end
      S_MMSI: begin
        emit     = 1'b1;
        e_res.ch = (k_q < 5'd9) ? CH_ZERO + {4'h0, mm_dig} : CH_COMMA;
      end
      S_HDR: begin
        emit = 1'b1;
        case (k_q)
          5'd0:    e_res.ch = CH_ZERO + {6'h0, chan_q};
          5'd2:    e_res.ch = (id_q >= 6'd10) ? CH_ONE : CH_ZERO + {2'b00, id_q};
          5'd3:    e_res.ch = CH_ZERO + {2'b00, id_q - 6'd10};
          default: e_res.ch = CH_COMMA;
        endcase
      end
      S_GAP: begin
        emit = 1'b1;
      end
      S_PAD: begin
        emit     = (cnt_q != 3'd0) || (bits_q == 10'd0);
        e_res.ch = (cnt_q != 3'd0) ? armor(pad_sym) : CH_ZERO;
      end
      S_CLOSE: begin
        emit  = 1'b1;
        e_sum = (k_q < 5'd2);
        case (k_q)
          5'd1:    e_res.ch = CH_ZERO + {5'h0, (final_q ? fill_q : 3'd0)};
          5'd2:    e_res.ch = CH_STAR;
          5'd3:    e_res.ch = hex_char(csum_q[7:4]);
          5'd4:    e_res.ch = hex_char(csum_q[3:0]);
          5'd5:    e_res.ch = CH_CR;
          5'd6: begin
            e_res.ch       = CH_LF;
            e_res.sent_end = 1'b1;
            e_res.msg_end  = final_q;
          end
          default: e_res.ch = CH_COMMA;
        endcase
      end
      S_BIT: begin
        emit     = (cnt_q == 3'd5);
        e_res.ch = armor(res_next);
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  assign out_free   = !out_v_q || out_ready_i;
  assign go         = (state_q == S_FLUSH) ? (!hold_v_q || out_free)
                                           : (!emit || !hold_v_q || out_free);
  assign do_push    = emit && go;
  assign do_flush   = (state_q == S_FLUSH) && hold_v_q && out_free;
  assign item_pop_o = (state_q == S_IDLE) && item_valid_i;

  // ---- next state -----------------------------------------------------------
  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    if (go) begin
      unique case (state_q)
        S_IDLE: begin
          k_d = 5'd0;
          if (item_valid_i) begin
            if (item_i.first) begin
              state_d = (item_i.err != ERR_NONE) ? S_ERR : S_OPEN;
            end else if (busy_q) begin
              state_d = S_BIT;
            end
          end
        end
        S_ERR: state_d = S_FLUSH;
        S_OPEN: begin
          if (k_q == 5'd12) begin
            k_d     = 5'd0;
            state_d = (idx_q != 4'd0) ? S_GAP : (addr_q ? S_MMSI : S_HDR);
          end else begin
            k_d = k_q + 5'd1;
          end
        end
        S_MMSI: begin
          if (k_q == 5'd9) begin
            k_d     = 5'd0;
            state_d = S_HDR;
          end else begin
            k_d = k_q + 5'd1;
          end
        end
        S_HDR: begin
          if (k_q == 5'd4) begin
            state_d = S_CHECK;
          end else if (k_q == 5'd2 && id_q < 6'd10) begin
            k_d = 5'd4;
          end else begin
            k_d = k_q + 5'd1;
          end
        end
        S_GAP: begin
          if (k_q == (addr_q ? 5'd2 : 5'd1)) begin
            state_d = S_CHECK;
          end else begin
            k_d = k_q + 5'd1;
          end
        end
        S_CHECK: begin
          k_d = 5'd0;
          if (final_cond) begin
            state_d = S_PAD;
          end else if (pos_q >= lim_q) begin
            state_d = S_CLOSE;
          end else if (more_q) begin
            state_d = S_BIT;
          end else begin
            state_d = S_FLUSH;
          end
        end
        S_PAD: begin
          k_d     = 5'd0;
          state_d = S_CLOSE;
        end
        S_CLOSE: begin
          if (k_q == 5'd6) begin
            k_d     = 5'd0;
            state_d = final_q ? S_FLUSH : S_OPEN;
          end else begin
            k_d = k_q + 5'd1;
          end
        end
        S_BIT: begin
          if (hit_next) begin
            state_d = S_CHECK;
          end else if (bit_q != 3'd0) begin
            state_d = S_BIT;
          end else begin
            state_d = S_FLUSH;
          end
        end
        S_FLUSH: state_d = S_IDLE;
        default: state_d = S_IDLE;
      endcase
    end
  end

  // ---- datapath next values -------------------------------------------------
  always_comb begin
    seq_d = seq_q;   pos_d = pos_q;   res_d = res_q;   cnt_d = cnt_q;
    idx_d = idx_q;   tot_d = tot_q;   lim_d = lim_q;   csum_d = csum_q;
    mm_d = mm_q;     id_d = id_q;     chan_d = chan_q; bits_d = bits_q;
    fill_d = fill_q; err_d = err_q;   addr_d = addr_q; busy_d = busy_q;
    data_d = data_q; bit_d = bit_q;   more_d = more_q; final_d = final_q;

    if (do_push && e_sum) begin
      csum_d = csum_q ^ e_res.ch;
    end
    if (go) begin
      case (state_q)
        S_IDLE: begin
          if (item_valid_i) begin
            data_d = item_i.data;
            bit_d  = 3'd7;
            more_d = 1'b1;
            if (item_i.first) begin
              mm_d   = item_i.mmsi;
              id_d   = item_i.id;
              chan_d = item_i.chan;
              bits_d = item_i.bits;
              fill_d = item_i.fill;
              err_d  = item_i.err;
              addr_d = item_i.addr;
              tot_d  = item_i.total;
              lim_d  = item_i.limit;
              busy_d = (item_i.err == ERR_NONE);
              if (item_i.err == ERR_NONE) begin
                // Wrap the sequence id into the range of this message type.
                if (item_i.addr) begin
                  seq_d = {2'b00, seq_q[1:0]};
                end else if (seq_q >= 4'd10) begin
                  seq_d = seq_q - 4'd10;
                end
                pos_d = 10'd0;
                res_d = 6'd0;
                cnt_d = 3'd0;
                idx_d = 4'd0;
              end
            end
          end
        end
        S_OPEN: begin
          if (k_q == 5'd0) begin
            csum_d = 8'd0;
          end
        end
        S_MMSI: begin
          if (k_q < 5'd9) begin
            mm_d = 30'({mm_rem, 3'b000}) + 30'({mm_rem, 1'b0});
          end
        end
        S_CHECK: begin
          final_d = final_cond;
        end
        S_PAD: begin
          cnt_d = 3'd0;
          res_d = 6'd0;
        end
        S_CLOSE: begin
          if (k_q == 5'd6) begin
            if (final_q) begin
              busy_d = 1'b0;
              seq_d  = seq_q + 4'd1;
            end else begin
              idx_d = idx_q + 4'd1;
              lim_d = (lim_sum > 11'(BIT_LIMIT_MAX)) ? 10'(BIT_LIMIT_MAX) : lim_sum[9:0];
            end
          end
        end
        S_BIT: begin
          pos_d  = pos_inc[9:0];
          bit_d  = bit_q - 3'd1;
          more_d = (bit_q != 3'd0);
          if (cnt_q == 3'd5) begin
            cnt_d = 3'd0;
            res_d = 6'd0;
          end else begin
            cnt_d = cnt_q + 3'd1;
            res_d = res_next;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;  k_q <= 5'd0;    seq_q <= 4'd0;   pos_q <= 10'd0;
      res_q <= 6'd0;      cnt_q <= 3'd0;  idx_q <= 4'd0;   tot_q <= 4'd0;
      lim_q <= 10'd0;     csum_q <= 8'd0; mm_q <= 30'd0;   id_q <= 6'd0;
      chan_q <= 2'd0;     bits_q <= 10'd0; fill_q <= 3'd0; err_q <= ERR_NONE;
      addr_q <= 1'b0;     busy_q <= 1'b0; data_q <= 8'd0;  bit_q <= 3'd0;
      more_q <= 1'b0;     final_q <= 1'b0;
      hold_v_q <= 1'b0;   out_v_q <= 1'b0;
    end else begin
      state_q <= state_d; k_q <= k_d;       seq_q <= seq_d;   pos_q <= pos_d;
      res_q <= res_d;     cnt_q <= cnt_d;   idx_q <= idx_d;   tot_q <= tot_d;
      lim_q <= lim_d;     csum_q <= csum_d; mm_q <= mm_d;     id_q <= id_d;
      chan_q <= chan_d;   bits_q <= bits_d; fill_q <= fill_d; err_q <= err_d;
      addr_q <= addr_d;   busy_q <= busy_d; data_q <= data_d; bit_q <= bit_d;
      more_q <= more_d;   final_q <= final_d;
      if (do_push) begin
        hold_v_q <= 1'b1;
      end else if (do_flush) begin
        hold_v_q <= 1'b0;
      end
      if ((do_push && hold_v_q) || do_flush) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  // Hold one character back so the last one of an item can carry run_last.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      hold_q <= e_res;
    end
    if ((do_push && hold_v_q) || do_flush) begin
      out_q    <= hold_q;
      out_rl_q <= do_flush;
    end
  end

  assign out_valid_o    = out_v_q;
  assign out_char_o     = out_q.ch;
  assign sentence_end_o = out_q.sent_end;
  assign message_end_o  = out_q.msg_end;
  assign run_last_o     = out_rl_q;
  assign error_code_o   = out_q.err;

endmodule
`default_nettype wire
